[rtl/core/rhsv_pkg.sv]
// Shared types and constants for the RGB to HSV converter.
// No dependencies; imported by every module of the block.
package rhsv_pkg;

    localparam int CH_W   = 8;              // colour channel width
    localparam int HUE_W  = 15;             // hue, degrees * 64
    localparam int QUO_W  = 12;             // quotient bits, one per divider stage
    localparam int REM_W  = 20;             // dividend / partial remainder width

    localparam logic [11:0] HUE_SCALE      = 12'd3840;   // 60 degrees * 64
    localparam logic signed [15:0] HUE_FULL       = 16'sd23040;
    localparam logic signed [15:0] HUE_GREEN_BASE = 16'sd7680;
    localparam logic signed [15:0] HUE_BLUE_BASE  = 16'sd15360;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sector_t;

    // fields that ride alongside the two divisions
    typedef struct packed {
        logic [CH_W-1:0] mx;
        logic            sat_zero;
        logic            hue_zero;
        logic            neg;
        sector_t         sector;
    } side_t;

    typedef struct packed {
        logic [REM_W-1:0] num_h;
        logic [CH_W-1:0]  den_h;
        logic [REM_W-1:0] num_s;
        logic [CH_W-1:0]  den_s;
        side_t            side;
    } prep_t;

    typedef struct packed {
        logic [QUO_W-1:0] q_h;
        logic [QUO_W-1:0] q_s;
        side_t            side;
    } quot_t;

endpackage

[rtl/core/rhsv_prep.sv]
// Front end: two register stages finding max, min, sector and the
// dividends for hue and saturation. Depends on rhsv_pkg.
module rhsv_prep
    import rhsv_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [CH_W-1:0] red_in,
    input  logic [CH_W-1:0] green_in,
    input  logic [CH_W-1:0] blue_in,
    output logic            out_valid,
    input  logic            out_ready,
    output prep_t           out_data
);

    logic            a_valid_reg;
    logic [CH_W-1:0] a_mx_reg;
    logic [CH_W-1:0] a_mn_reg;
    sector_t         a_sec_reg;
    logic            a_neg_reg;
    logic [CH_W-1:0] a_mag_reg;

    logic            b_valid_reg;
    prep_t           b_data_reg;

    logic            a_rdy;
    logic            b_rdy;

    logic [CH_W-1:0] mx_next;
    logic [CH_W-1:0] mn_next;
    sector_t         sec_next;
    logic [CH_W:0]   n_next;      // signed difference, 9 bits
    logic [CH_W-1:0] mag_next;

    prep_t           b_data_next;
    logic [CH_W-1:0] d_val;

    assign b_rdy    = !b_valid_reg || out_ready;
    assign a_rdy    = !a_valid_reg || b_rdy;
    assign in_ready = a_rdy;

    always_comb
    begin
        mx_next = red_in;
        if (green_in > mx_next)
        begin
            mx_next = green_in;
        end
        if (blue_in > mx_next)
        begin
            mx_next = blue_in;
        end
        mn_next = red_in;
        if (green_in < mn_next)
        begin
            mn_next = green_in;
        end
        if (blue_in < mn_next)
        begin
            mn_next = blue_in;
        end
        // red wins ties, then green
        if (mx_next == red_in)
        begin
            sec_next = SEC_RED;
            n_next   = {1'b0, green_in} - {1'b0, blue_in};
        end
        else if (mx_next == green_in)
        begin
            sec_next = SEC_GREEN;
            n_next   = {1'b0, blue_in} - {1'b0, red_in};
        end
        else
        begin
            sec_next = SEC_BLUE;
            n_next   = {1'b0, red_in} - {1'b0, green_in};
        end
        mag_next = n_next[CH_W] ? CH_W'(-n_next) : n_next[CH_W-1:0];
    end

    always_comb
    begin
        d_val                     = a_mx_reg - a_mn_reg;
        b_data_next.num_h         = REM_W'(a_mag_reg) * REM_W'(HUE_SCALE);
        b_data_next.den_h         = d_val;
        b_data_next.num_s         = REM_W'({d_val, 8'd0}) - REM_W'(d_val);  // d * 255
        b_data_next.den_s         = a_mx_reg;
        b_data_next.side.mx       = a_mx_reg;
        b_data_next.side.sat_zero = (a_mx_reg == '0);
        b_data_next.side.hue_zero = (d_val == '0);
        b_data_next.side.neg      = a_neg_reg;
        b_data_next.side.sector   = a_sec_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_rdy)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_rdy)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_rdy && in_valid)
        begin
            a_mx_reg  <= mx_next;
            a_mn_reg  <= mn_next;
            a_sec_reg <= sec_next;
            a_neg_reg <= n_next[CH_W];
            a_mag_reg <= mag_next;
        end
        if (b_rdy && a_valid_reg)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

[rtl/core/rhsv_div.sv]
// Pipelined restoring divider, two lanes in lockstep (hue and saturation),
// one quotient bit per stage. Depends on rhsv_pkg.
module rhsv_div
    import rhsv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  prep_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output quot_t out_data
);

    logic             valid_reg [QUO_W];
    logic [REM_W-1:0] rem_h_reg [QUO_W];
    logic [REM_W-1:0] rem_s_reg [QUO_W];
    logic [CH_W-1:0]  den_h_reg [QUO_W];
    logic [CH_W-1:0]  den_s_reg [QUO_W];
    logic [QUO_W-1:0] q_h_reg   [QUO_W];
    logic [QUO_W-1:0] q_s_reg   [QUO_W];
    side_t            side_reg  [QUO_W];

    logic             rdy [QUO_W+1];

    assign rdy[QUO_W] = out_ready;
    assign in_ready   = rdy[0];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++)
        begin : g_stage
            localparam int BIT = QUO_W - 1 - k;

            logic             src_valid;
            logic [REM_W-1:0] src_rem_h;
            logic [REM_W-1:0] src_rem_s;
            logic [CH_W-1:0]  src_den_h;
            logic [CH_W-1:0]  src_den_s;
            logic [QUO_W-1:0] src_q_h;
            logic [QUO_W-1:0] src_q_s;
            side_t            src_side;

            logic [REM_W-1:0] trial_h;
            logic [REM_W-1:0] trial_s;
            logic             ge_h;
            logic             ge_s;

            if (k == 0)
            begin : g_first
                assign src_valid = in_valid;
                assign src_rem_h = in_data.num_h;
                assign src_rem_s = in_data.num_s;
                assign src_den_h = in_data.den_h;
                assign src_den_s = in_data.den_s;
                assign src_q_h   = '0;
                assign src_q_s   = '0;
                assign src_side  = in_data.side;
            end
            else
            begin : g_next
                assign src_valid = valid_reg[k-1];
                assign src_rem_h = rem_h_reg[k-1];
                assign src_rem_s = rem_s_reg[k-1];
                assign src_den_h = den_h_reg[k-1];
                assign src_den_s = den_s_reg[k-1];
                assign src_q_h   = q_h_reg[k-1];
                assign src_q_s   = q_s_reg[k-1];
                assign src_side  = side_reg[k-1];
            end

            assign trial_h = REM_W'(src_den_h) << BIT;
            assign trial_s = REM_W'(src_den_s) << BIT;
            assign ge_h    = (src_rem_h >= trial_h);
            assign ge_s    = (src_rem_s >= trial_s);

            assign rdy[k] = !valid_reg[k] || rdy[k+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (rdy[k])
                begin
                    valid_reg[k] <= src_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k] && src_valid)
                begin
                    rem_h_reg[k] <= ge_h ? (src_rem_h - trial_h) : src_rem_h;
                    rem_s_reg[k] <= ge_s ? (src_rem_s - trial_s) : src_rem_s;
                    den_h_reg[k] <= src_den_h;
                    den_s_reg[k] <= src_den_s;
                    q_h_reg[k]   <= src_q_h | (QUO_W'(ge_h) << BIT);
                    q_s_reg[k]   <= src_q_s | (QUO_W'(ge_s) << BIT);
                    side_reg[k]  <= src_side;
                end
            end
        end
    endgenerate

    assign out_valid     = valid_reg[QUO_W-1];
    assign out_data.q_h  = q_h_reg[QUO_W-1];
    assign out_data.q_s  = q_s_reg[QUO_W-1];
    assign out_data.side = side_reg[QUO_W-1];

endmodule

[rtl/core/rhsv_post.sv]
// Back end: sign and sector offset on the hue, wrap, special cases,
// and the output register. Depends on rhsv_pkg.
module rhsv_post
    import rhsv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  quot_t            in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [HUE_W-1:0] hue_out,
    output logic [CH_W-1:0]  saturation_out,
    output logic [CH_W-1:0]  value_out
);

    logic             valid_reg;
    logic [HUE_W-1:0] hue_reg;
    logic [CH_W-1:0]  sat_reg;
    logic [CH_W-1:0]  val_reg;

    logic signed [15:0] h_q;
    logic signed [15:0] h_base;
    logic signed [15:0] h_sum;
    logic [HUE_W-1:0]   hue_next;
    logic [CH_W-1:0]    sat_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        h_q = $signed(16'(in_data.q_h));
        if (in_data.side.neg)
        begin
            h_q = -h_q;
        end
        case (in_data.side.sector)
            SEC_RED:   h_base = 16'sd0;
            SEC_GREEN: h_base = HUE_GREEN_BASE;
            SEC_BLUE:  h_base = HUE_BLUE_BASE;
            default:   h_base = 16'sd0;
        endcase
        h_sum = h_q + h_base;
        if (h_sum < 16'sd0)
        begin
            h_sum = h_sum + HUE_FULL;
        end
        hue_next = in_data.side.hue_zero ? '0 : h_sum[HUE_W-1:0];
        sat_next = in_data.side.sat_zero ? '0 : in_data.q_s[CH_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= in_data.side.mx;
        end
    end

    assign out_valid      = valid_reg;
    assign hue_out        = hue_reg;
    assign saturation_out = sat_reg;
    assign value_out      = val_reg;

endmodule

[rtl/core/rgb_to_hsv_converter_top.sv]
// RGB to HSV converter, top level.
// Depends on rhsv_pkg, rhsv_prep, rhsv_div and rhsv_post.
//
// Use:
//   s_* carries one 8-bit RGB pixel per request, m_* one HSV result per
//   request. A request moves on a rising edge with tvalid and tready high.
//   Hue is degrees * 64 (0..23039), saturation floor(d*255/max), value the
//   largest channel.
// Pipeline: 2 front-end stages, 12 divider stages, 1 output register.
// Throughput: one pixel per cycle while m_tready does not stall the
//   output; both divisions run in a 12-stage restoring divider pipeline,
//   one quotient bit per stage.
// Reset: rst_n clears every stage valid bit; the pipeline comes up empty.
// Stall: each stage holds its request while the one after it is full and
//   stalled, so empty stages still fill; s_tready falls only once every
//   stage holds a pixel. Nothing is dropped or repeated.
// No state is kept between pixels.
module rgb_to_hsv_converter_top
    import rhsv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // hue_out[14:0], saturation_out[22:15],
                                   // value_out[30:23], zero[31]
);

    logic             prep_valid;
    logic             prep_ready;
    prep_t            prep_data;
    logic             div_valid;
    logic             div_ready;
    quot_t            div_data;
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  val;

    rhsv_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .red_in    (s_tdata[7:0]),
        .green_in  (s_tdata[15:8]),
        .blue_in   (s_tdata[23:16]),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    rhsv_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    rhsv_post u_post
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (div_valid),
        .in_ready       (div_ready),
        .in_data        (div_data),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .hue_out        (hue),
        .saturation_out (sat),
        .value_out      (val)
    );

    assign m_tdata = {1'b0, val, sat, hue};

endmodule
